@@ hdl/dq_pkg.sv @@
// Shared types and constants for the double-ended queue core.
// Holds the request and response payload structs and the operation codes.
// No dependencies.
package dq_pkg;

    localparam int WORD_W  = 32;
    localparam int FUNC_W  = 3;
    localparam int COUNT_W = 11;

    // Operation codes carried in the func field
    localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_READ_FRONT = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_READ_BACK  = 3'd5;

    // Word returned by a pop or read on an empty deque
    localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [WORD_W-1:0] push_value;
    } dq_req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] out_value;
        logic [COUNT_W-1:0]       count;
        logic                     is_empty;
        logic                     rejected;
    } dq_rsp_t;

    // Source of the returned word
    typedef enum logic [1:0] {
        VAL_ZERO  = 2'b00,
        VAL_EMPTY = 2'b01,
        VAL_MEM   = 2'b10
    } dq_val_sel_t;

    // Per-operation status from the pointer unit, held until the read returns
    typedef struct packed {
        dq_val_sel_t        val_sel;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
        logic               rejected;
    } dq_meta_t;

endpackage

@@ hdl/dq_ram.sv @@
// Word store of the double-ended queue: single-port synchronous RAM.
// One write or one registered read per cycle. Uses dq_pkg for the word width.
module dq_ram #(
    parameter int DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic                                  rd_en,
    input  logic [$clog2(DEPTH)-1:0]              addr,
    input  logic signed [dq_pkg::WORD_W-1:0]      wdata,
    output logic signed [dq_pkg::WORD_W-1:0]      rdata
);
    import dq_pkg::*;

    logic signed [WORD_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

@@ hdl/dq_ptr.sv @@
// Pointer unit: head pointer and fill count, ring address generation and
// per-operation status. Uses dq_pkg for operation codes and the status struct.
module dq_ptr #(
    parameter int DEPTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  logic [dq_pkg::FUNC_W-1:0]     func,
    output logic [$clog2(DEPTH)-1:0]      addr,
    output logic                          wr_en,
    output logic                          rd_en,
    output dq_pkg::dq_meta_t              meta
);
    import dq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = PTR_W + 2;

    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(DEPTH - 1);

    logic [PTR_W-1:0] head_reg, head_next, head_upd;
    logic [CNT_W-1:0] fill_reg, fill_next, fill_upd;

    logic             full, empty;
    logic [SUM_W-1:0] sum_tail, sum_back, idx_tail, idx_back;
    logic [PTR_W-1:0] tail_ptr, back_ptr, head_dec, head_inc;
    logic             wr_op, rd_op;
    dq_val_sel_t      val_sel;
    logic             rej;
    logic [CNT_W+COUNT_W-1:0] cnt_wide;

    assign full  = (fill_reg == DEPTH_C);
    assign empty = (fill_reg == '0);

    // Ring positions: slot after the back word, and the back word itself
    assign sum_tail = SUM_W'(head_reg) + SUM_W'(fill_reg);
    assign sum_back = sum_tail - SUM_W'(1);
    assign idx_tail = (sum_tail >= DEPTH_S) ? (sum_tail - DEPTH_S) : sum_tail;
    assign idx_back = (sum_back >= DEPTH_S) ? (sum_back - DEPTH_S) : sum_back;
    assign tail_ptr = idx_tail[PTR_W-1:0];
    assign back_ptr = idx_back[PTR_W-1:0];

    assign head_dec = (head_reg == '0) ? LAST_P : (head_reg - PTR_W'(1));
    assign head_inc = (head_reg == LAST_P) ? '0 : (head_reg + PTR_W'(1));

    // Operation decode
    always_comb
    begin
        addr     = head_reg;
        wr_op    = 1'b0;
        rd_op    = 1'b0;
        head_upd = head_reg;
        fill_upd = fill_reg;
        val_sel  = VAL_ZERO;
        rej      = 1'b0;
        unique case (func) inside
            FUNC_PUSH_FRONT:
            begin
                if (full)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    addr     = head_dec;
                    wr_op    = 1'b1;
                    head_upd = head_dec;
                    fill_upd = fill_reg + CNT_W'(1);
                end
            end
            FUNC_PUSH_BACK:
            begin
                if (full)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    addr     = tail_ptr;
                    wr_op    = 1'b1;
                    fill_upd = fill_reg + CNT_W'(1);
                end
            end
            FUNC_POP_FRONT, FUNC_READ_FRONT:
            begin
                if (empty)
                begin
                    val_sel = VAL_EMPTY;
                end
                else
                begin
                    rd_op   = 1'b1;
                    val_sel = VAL_MEM;
                    if (func == FUNC_POP_FRONT)
                    begin
                        head_upd = head_inc;
                        fill_upd = fill_reg - CNT_W'(1);
                    end
                end
            end
            FUNC_POP_BACK, FUNC_READ_BACK:
            begin
                if (empty)
                begin
                    val_sel = VAL_EMPTY;
                end
                else
                begin
                    addr    = back_ptr;
                    rd_op   = 1'b1;
                    val_sel = VAL_MEM;
                    if (func == FUNC_POP_BACK)
                    begin
                        fill_upd = fill_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                // unused codes: no operation
            end
        endcase
    end

    assign wr_en     = take & wr_op;
    assign rd_en     = take & rd_op;
    assign head_next = take ? head_upd : head_reg;
    assign fill_next = take ? fill_upd : fill_reg;

    // Status after this operation; count reported in its low bits
    assign cnt_wide      = {{COUNT_W{1'b0}}, fill_upd};
    assign meta.val_sel  = val_sel;
    assign meta.count    = cnt_wide[COUNT_W-1:0];
    assign meta.is_empty = (fill_upd == '0);
    assign meta.rejected = rej;

    // Pointer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

endmodule

@@ hdl/double_ended_queue_core.sv @@
// Double-ended queue of signed 32-bit words in a ring of DEPTH RAM entries.
// A request is not taken while an earlier one is in flight. In the cycle of
// the transfer the pointer unit moves the head pointer and fill count and
// issues the single RAM access, and in the next cycle the registered RAM read
// returns and the response is formed. Responses go to an output register with
// a one-entry skid stage, so a request is still taken while a finished
// response waits; with the skid occupied requests stall until it drains.
// Each request gives exactly one response. Pushes to a full deque are dropped
// and flagged rejected; pops and reads of an empty deque return -1. The RAM
// needs no clearing after reset. Depends on dq_pkg, dq_ptr and dq_ram.
module double_ended_queue_core #(
    parameter int DEPTH = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  dq_pkg::dq_req_t  req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output dq_pkg::dq_rsp_t  rsp
);
    import dq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);

    logic                     take, take_out, out_free;
    logic [PTR_W-1:0]         ram_addr;
    logic                     ram_wr, ram_rd;
    logic signed [WORD_W-1:0] ram_rdata;
    dq_meta_t                 meta;

    logic     pend_reg, pend_next;
    dq_meta_t meta_reg;
    logic     out_valid_reg, out_valid_next;
    logic     skid_valid_reg, skid_valid_next;
    dq_rsp_t  out_reg, out_next;
    dq_rsp_t  skid_reg, skid_next;
    dq_rsp_t  res_now;

    // Interlock: one request in flight, skid must be free
    assign req_stall = pend_reg | skid_valid_reg;
    assign take      = req_valid & ~req_stall;
    assign take_out  = out_valid_reg & ~rsp_stall;
    assign out_free  = ~out_valid_reg | take_out;

    dq_ptr #(
        .DEPTH (DEPTH)
    ) u_ptr (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .func  (req.func),
        .addr  (ram_addr),
        .wr_en (ram_wr),
        .rd_en (ram_rd),
        .meta  (meta)
    );

    dq_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .wr_en (ram_wr),
        .rd_en (ram_rd),
        .addr  (ram_addr),
        .wdata (req.push_value),
        .rdata (ram_rdata)
    );

    // Response formed when the read returns
    always_comb
    begin
        case (meta_reg.val_sel)
            VAL_MEM:   res_now.out_value = ram_rdata;
            VAL_EMPTY: res_now.out_value = EMPTY_WORD;
            default:   res_now.out_value = '0;
        endcase
        res_now.count    = meta_reg.count;
        res_now.is_empty = meta_reg.is_empty;
        res_now.rejected = meta_reg.rejected;
    end

    // Output register and skid stage
    always_comb
    begin
        pend_next       = take;
        out_valid_next  = out_valid_reg & ~take_out;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (pend_reg)
        begin
            if (out_free)
            begin
                out_next       = res_now;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res_now;
                skid_valid_next = 1'b1;
            end
        end
        else if (skid_valid_reg && out_free)
        begin
            out_next        = skid_reg;
            out_valid_next  = 1'b1;
            skid_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            meta_reg <= meta;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

@@ test/tb_double_ended_queue_core.sv @@
// Self-checking testbench for double_ended_queue_core: directed and random request
// transfers with idle and stall patterns, checked against an in-bench deque predictor.
// Depends on dq_pkg and the double_ended_queue_core RTL.
module tb_double_ended_queue_core;
    timeunit 1ns;
    timeprecision 1ps;

    import dq_pkg::*;

    localparam int DEPTH        = 1024;
    localparam int PHASE_ITEMS  = 60;
    localparam int RUN_LIMIT_NS = 2_000_000;
    localparam int SETTLE_CYC   = 20;
    localparam int DRAIN_CYC    = 20000;

    // func codes the block treats as no-ops
    localparam logic [FUNC_W-1:0] FUNC_NOOP_LO = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_NOOP_HI = 3'd7;

    typedef enum int
    {
        MIX_ANY,
        MIX_GROW,
        MIX_SHRINK
    } mix_kind_t;

    // Deque model plus the queue of responses still owed by the block
    class deque_scoreboard;
        logic signed [WORD_W-1:0] words [DEPTH];
        int unsigned              head = 0;
        int unsigned              fill = 0;
        dq_rsp_t                  rsp_due [$];
        int unsigned              n_fail = 0;
        int unsigned              n_checked = 0;
        int unsigned              n_rejected = 0;
        int unsigned              peak_fill = 0;

        // apply one accepted request and queue the response it should give
        function void note_request(dq_req_t r);
            dq_rsp_t     e;
            int unsigned back;
            e = '0;
            back = (head + fill + DEPTH - 1) % DEPTH;
            case (r.func)
                FUNC_PUSH_FRONT:
                begin
                    if (fill >= DEPTH)
                    begin
                        e.rejected = 1'b1;
                    end
                    else
                    begin
                        head = (head + DEPTH - 1) % DEPTH;
                        words[head] = r.push_value;
                        fill++;
                    end
                end
                FUNC_PUSH_BACK:
                begin
                    if (fill >= DEPTH)
                    begin
                        e.rejected = 1'b1;
                    end
                    else
                    begin
                        words[(head + fill) % DEPTH] = r.push_value;
                        fill++;
                    end
                end
                FUNC_POP_FRONT:
                begin
                    if (fill == 0)
                    begin
                        e.out_value = EMPTY_WORD;
                    end
                    else
                    begin
                        e.out_value = words[head];
                        head = (head + 1) % DEPTH;
                        fill--;
                    end
                end
                FUNC_POP_BACK:
                begin
                    if (fill == 0)
                    begin
                        e.out_value = EMPTY_WORD;
                    end
                    else
                    begin
                        e.out_value = words[back];
                        fill--;
                    end
                end
                FUNC_READ_FRONT:
                    e.out_value = (fill == 0) ? EMPTY_WORD : words[head];
                FUNC_READ_BACK:
                    e.out_value = (fill == 0) ? EMPTY_WORD : words[back];
                default: ;
            endcase
            e.count    = COUNT_W'(fill);
            e.is_empty = (fill == 0);
            if (e.rejected)
            begin
                n_rejected++;
            end
            if (fill > peak_fill)
            begin
                peak_fill = fill;
            end
            rsp_due.push_back(e);
        endfunction

        // compare one accepted response with the oldest one owed
        function void check_response(dq_rsp_t got);
            dq_rsp_t e;
            if (rsp_due.size() == 0)
            begin
                $display("%0t: response with none due: out_value %0d count %0d",
                         $time, got.out_value, got.count);
                n_fail++;
                return;
            end
            e = rsp_due.pop_front();
            n_checked++;
            if (got.out_value !== e.out_value)
            begin
                $display("%0t: out_value expected %0d actual %0d",
                         $time, e.out_value, got.out_value);
                n_fail++;
            end
            if (got.count !== e.count)
            begin
                $display("%0t: count expected %0d actual %0d", $time, e.count, got.count);
                n_fail++;
            end
            if (got.is_empty !== e.is_empty)
            begin
                $display("%0t: is_empty expected %b actual %b",
                         $time, e.is_empty, got.is_empty);
                n_fail++;
            end
            if (got.rejected !== e.rejected)
            begin
                $display("%0t: rejected expected %b actual %b",
                         $time, e.rejected, got.rejected);
                n_fail++;
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    req_valid;
    logic    req_stall;
    dq_req_t req;
    logic    rsp_valid;
    logic    rsp_stall;
    dq_rsp_t rsp;

    int      send_idle = 0;
    int      recv_idle = 0;
    int      n_sent = 0;

    deque_scoreboard sb = new();

    double_ended_queue_core #(
        .DEPTH (DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Word source weighted towards the extremes
    function automatic logic signed [WORD_W-1:0] make_word();
        case ($urandom_range(7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // One request drawn from the given operation mix
    function automatic dq_req_t make_item(mix_kind_t kind);
        dq_req_t r;
        logic    push_side;
        int      pick;
        pick = $urandom_range(99);
        push_side = 1'($urandom_range(1));
        r.push_value = make_word();
        case (kind)
            MIX_GROW:
                r.func = (pick < 70) ? (push_side ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT)
                                     : FUNC_W'($urandom_range(FUNC_READ_BACK, FUNC_POP_FRONT));
            MIX_SHRINK:
                r.func = (pick < 70) ? FUNC_W'($urandom_range(FUNC_READ_BACK, FUNC_POP_FRONT))
                                     : (push_side ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT);
            default:
                r.func = FUNC_W'($urandom_range(FUNC_NOOP_HI, FUNC_PUSH_FRONT));
        endcase
        return r;
    endfunction

    // Present one request, idling first at random, and hold it until the transfer
    task automatic send_item(input dq_req_t item);
        while ($urandom_range(99) < send_idle)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        sb.note_request(item);
        n_sent++;
    endtask

    task automatic send_op(input logic [FUNC_W-1:0] func, input logic signed [WORD_W-1:0] value);
        dq_req_t item;
        item.func       = func;
        item.push_value = value;
        send_item(item);
    endtask

    // Hold the request side off until every owed response has come back
    task automatic wait_quiet();
        req_valid <= 1'b0;
        while (sb.rsp_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Random bursts of one mix at a time; a quiet pause half way through
    task automatic run_phase(input int s_idle, input int r_idle, input int budget);
        dq_req_t   item;
        mix_kind_t kind;
        int        done;
        int        left;
        bit        paused;
        send_idle = s_idle;
        recv_idle = r_idle;
        done   = 0;
        left   = 0;
        paused = 1'b0;
        kind   = MIX_ANY;
        while (done < budget)
        begin
            if (left == 0)
            begin
                kind = mix_kind_t'($urandom_range(MIX_SHRINK, MIX_ANY));
                left = $urandom_range(40, 8);
            end
            item = make_item(kind);
            send_item(item);
            left--;
            if (item.func <= FUNC_READ_BACK)
            begin
                done++;
            end
            if (!paused && done >= budget / 2)
            begin
                paused = 1'b1;
                wait_quiet();
            end
        end
    endtask

    // Push until full, then work both ends around the full boundary
    task automatic fill_to_capacity();
        while (sb.fill < DEPTH)
        begin
            send_op($urandom_range(1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT, make_word());
        end
        send_op(FUNC_PUSH_FRONT, make_word());
        send_op(FUNC_PUSH_BACK, make_word());
        send_op(FUNC_READ_FRONT, make_word());
        send_op(FUNC_READ_BACK, make_word());
        repeat (60)
        begin
            send_item(make_item(MIX_GROW));
        end
        repeat (120)
        begin
            send_item(make_item(MIX_SHRINK));
        end
    endtask

    // Response side: check each transfer, stall at random
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
            begin
                sb.check_response(rsp);
            end
            rsp_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    // Run limit
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("[double_ended_queue_core] ERROR");
        $finish;
    end

    // Main sequence
    initial
    begin
        int guard;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty accesses, no-op codes, both ends, wrap of the head
        send_idle = 20;
        recv_idle = 20;
        send_op(FUNC_POP_FRONT, 32'sh0000_0000);
        send_op(FUNC_POP_BACK, 32'sh7FFF_FFFF);
        send_op(FUNC_READ_FRONT, -32'sd1);
        send_op(FUNC_READ_BACK, 32'sh8000_0000);
        send_op(FUNC_NOOP_LO, 32'sh1234_5678);
        send_op(FUNC_NOOP_HI, -32'sd1);
        send_op(FUNC_PUSH_FRONT, 32'sh7FFF_FFFF);
        send_op(FUNC_PUSH_BACK, 32'sh8000_0000);
        send_op(FUNC_READ_FRONT, 32'sh0000_0000);
        send_op(FUNC_READ_BACK, 32'sh0000_0000);
        send_op(FUNC_PUSH_FRONT, 32'sh0000_0000);
        send_op(FUNC_PUSH_BACK, -32'sd1);
        send_op(FUNC_NOOP_HI, 32'sh5A5A_5A5A);
        send_op(FUNC_PUSH_FRONT, 32'sh5555_5555);
        send_op(FUNC_PUSH_BACK, 32'shAAAA_AAAA);
        send_op(FUNC_POP_FRONT, -32'sd1);
        send_op(FUNC_POP_BACK, -32'sd1);
        send_op(FUNC_READ_FRONT, 32'sh0000_0000);
        send_op(FUNC_READ_BACK, 32'sh0000_0000);
        send_op(FUNC_POP_BACK, 32'sh0000_0000);
        send_op(FUNC_POP_FRONT, 32'sh0000_0000);
        send_op(FUNC_POP_FRONT, 32'sh0000_0000);
        send_op(FUNC_POP_BACK, 32'sh0000_0000);
        send_op(FUNC_READ_BACK, 32'sh0000_0000);

        // random phases: sender mostly busy, then receiver mostly ready, then flat out
        run_phase(7, 73, PHASE_ITEMS);
        run_phase(73, 7, PHASE_ITEMS);
        run_phase(0, 0, PHASE_ITEMS);
        fill_to_capacity();

        // drain and settle
        req_valid <= 1'b0;
        guard = 0;
        while (sb.rsp_due.size() != 0 && guard < DRAIN_CYC)
        begin
            @(posedge clk);
            guard++;
        end
        if (sb.rsp_due.size() != 0)
        begin
            $display("%0t: %0d responses never arrived", $time, sb.rsp_due.size());
            sb.n_fail++;
        end
        repeat (SETTLE_CYC) @(posedge clk);

        $display("Covered %0d request transfers and %0d checked responses,",
                 n_sent, sb.n_checked);
        $display("with %0d pushes refused when full and a peak fill of %0d of %0d.",
                 sb.n_rejected, sb.peak_fill, DEPTH);
        if (sb.n_fail == 0)
        begin
            $display("[double_ended_queue_core] OK");
        end
        else
        begin
            $display("[double_ended_queue_core] ERROR");
        end
        $finish;
    end

endmodule
